// ===== rtl/sgpl_pkg.sv =====
// ----------------------------------------------------------------------------
// Smoothed gain peak limiter package
// Widths, configuration register indexes, reset values, the configuration
// bundle and the sequencer states shared by the limiter modules.
// ----------------------------------------------------------------------------
package sgpl_pkg;

    // Number of channels the frame format carries; at most two are processed.
    localparam int CHANNELS  = 2;
    localparam bit STEREO_OK = (CHANNELS >= 2);

    localparam int SAMPLE_W = 24;
    localparam int COEFF_W  = 24;
    localparam int GAIN_W   = 24;
    localparam int ENV_W    = 28;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 24;

    // Shared multiplier operand and product widths.
    localparam int MUL_W  = 28;
    localparam int PROD_W = 2 * MUL_W;

    // Unity in Q0.24, one bit wider than a coefficient.
    localparam logic [COEFF_W:0] ONE_Q24 = {1'b1, {COEFF_W{1'b0}}};

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENABLE          = 3'd0,
        CFG_CHANNEL_COUNT   = 3'd1,
        CFG_TARGET_GAIN     = 3'd2,
        CFG_LIMIT_THRESHOLD = 3'd3,
        CFG_ATTACK_COEFF    = 3'd4,
        CFG_RELEASE_COEFF   = 3'd5,
        CFG_SMOOTH_COEFF    = 3'd6
    } cfg_idx_t;

    // Configuration reset values.
    localparam logic                RST_ENABLE          = 1'b1;
    localparam logic [1:0]          RST_CHANNEL_COUNT   = 2'd2;
    localparam logic [GAIN_W-1:0]   RST_TARGET_GAIN     = 24'd1048576;
    localparam logic [GAIN_W-1:0]   RST_LIMIT_THRESHOLD = 24'd8388608;
    localparam logic [COEFF_W-1:0]  RST_ATTACK_COEFF    = 24'd16431301;
    localparam logic [COEFF_W-1:0]  RST_RELEASE_COEFF   = 24'd16773721;
    localparam logic [COEFF_W-1:0]  RST_SMOOTH_COEFF    = 24'd16742299;

    // State reset values: unity gain in Q4.20, empty envelope.
    localparam logic [GAIN_W-1:0]   RST_SMOOTHED_GAIN   = 24'd1048576;
    localparam logic [ENV_W-1:0]    RST_PEAK_ENVELOPE   = '0;

    // Configuration bundle handed from the register file to the core.
    typedef struct packed {
        logic                enable;
        logic [1:0]          channel_count;
        logic [GAIN_W-1:0]   target_gain;
        logic [GAIN_W-1:0]   limit_threshold;
        logic [COEFF_W-1:0]  attack_coeff;
        logic [COEFF_W-1:0]  release_coeff;
        logic [COEFF_W-1:0]  smooth_coeff;
    } cfg_t;

    // Sequencer states of the processing core.
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SMOOTH_A,
        ST_SMOOTH_B,
        ST_SMOOTH_C,
        ST_PEAK_L,
        ST_PEAK_R,
        ST_PEAK_C,
        ST_ENV_A,
        ST_ENV_B,
        ST_ENV_C,
        ST_DIV,
        ST_FINAL_A,
        ST_FINAL_C,
        ST_OUT_L,
        ST_OUT_R,
        ST_OUT_C,
        ST_DONE
    } state_t;

endpackage

// ===== rtl/sgpl_core.sv =====
// ----------------------------------------------------------------------------
// Smoothed gain peak limiter core
// Sequencer around one shared registered multiplier and a restoring divider
// step. Holds the smoothed gain and peak envelope state.
// ----------------------------------------------------------------------------
module sgpl_core (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  sgpl_pkg::cfg_t                       cfg,
    input  logic                                 start,
    input  logic signed [sgpl_pkg::SAMPLE_W-1:0] sample_left,
    input  logic signed [sgpl_pkg::SAMPLE_W-1:0] sample_right,
    output logic                                 idle,
    output logic                                 res_valid,
    input  logic                                 res_ready,
    output logic signed [sgpl_pkg::SAMPLE_W-1:0] res_left,
    output logic signed [sgpl_pkg::SAMPLE_W-1:0] res_right
);
    import sgpl_pkg::*;

    localparam logic [PROD_W-1:0] HALF_20 = PROD_W'(1) << 19;
    localparam logic [PROD_W-1:0] HALF_24 = PROD_W'(1) << 23;
    localparam logic [ENV_W-1:0]  NEG_LIM = ENV_W'(24'h800000);
    localparam logic [ENV_W-1:0]  POS_LIM = ENV_W'(24'h7FFFFF);

    // Magnitude of a signed sample; the most negative code maps to 2^23.
    function automatic logic [SAMPLE_W-1:0] mag(input logic [SAMPLE_W-1:0] s);
        mag = s[SAMPLE_W-1] ? (~s + 1'b1) : s;
    endfunction

    // Restore the sign of a rounded magnitude and saturate to 24 bits.
    function automatic logic [SAMPLE_W-1:0] sat(input logic neg,
                                                input logic [ENV_W-1:0] r);
        logic [ENV_W-1:0]    lim;
        logic [SAMPLE_W-1:0] m;
        lim = neg ? NEG_LIM : POS_LIM;
        m   = (r > lim) ? lim[SAMPLE_W-1:0] : r[SAMPLE_W-1:0];
        sat = neg ? (~m + 1'b1) : m;
    endfunction

    state_t               state_reg, state_next;
    logic [GAIN_W-1:0]    gain_reg, gain_next;
    logic [ENV_W-1:0]     env_reg, env_next;
    logic [ENV_W-1:0]     peak_reg, peak_next;
    logic [COEFF_W-1:0]   coef_reg, coef_next;
    logic [GAIN_W-1:0]    fgain_reg, fgain_next;
    logic [ENV_W-1:0]     rem_reg, rem_next;
    logic [GAIN_W-1:0]    quot_reg, quot_next;
    logic [4:0]           cnt_reg, cnt_next;
    logic [SAMPLE_W-1:0]  left_reg, left_next;
    logic [SAMPLE_W-1:0]  right_reg, right_next;
    logic                 stereo_reg, stereo_next;
    logic [SAMPLE_W-1:0]  out_l_reg, out_l_next;
    logic [SAMPLE_W-1:0]  out_r_reg, out_r_next;
    logic [PROD_W-1:0]    acc_reg, acc_next;
    logic [PROD_W-1:0]    prod_reg;

    logic [MUL_W-1:0]     mul_a, mul_b;
    logic [PROD_W-1:0]    sum_pole;
    logic [PROD_W-1:0]    sum_rnd20;
    logic [PROD_W-1:0]    sum_rnd24;
    logic [ENV_W-1:0]     prod_q20;
    logic [ENV_W-1:0]     env_new;
    logic [COEFF_W-1:0]   env_coef;
    logic [ENV_W:0]       trial;
    logic                 stereo_in;

    // Mono when fewer than two channels are asked for or carried.
    assign stereo_in = (cfg.channel_count >= 2'd2) && STEREO_OK;

    // Rounding of the accumulated one-pole sum and of the raw product.
    assign sum_pole  = acc_reg + prod_reg + HALF_24;
    assign sum_rnd20 = prod_reg + HALF_20;
    assign sum_rnd24 = prod_reg + HALF_24;
    assign prod_q20  = sum_rnd20[20 +: ENV_W];
    assign env_new   = sum_pole[24 +: ENV_W];
    assign env_coef  = (peak_reg > env_reg) ? cfg.attack_coeff : cfg.release_coeff;
    assign trial     = {rem_reg, 1'b0};

    // Operand selection for the shared multiplier.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_SMOOTH_A: begin
                mul_a = MUL_W'(cfg.smooth_coeff);
                mul_b = MUL_W'(gain_reg);
            end
            ST_SMOOTH_B: begin
                mul_a = MUL_W'(ONE_Q24 - {1'b0, cfg.smooth_coeff});
                mul_b = MUL_W'(cfg.target_gain);
            end
            ST_PEAK_L: begin
                mul_a = MUL_W'(mag(left_reg));
                mul_b = MUL_W'(gain_reg);
            end
            ST_PEAK_R: begin
                mul_a = MUL_W'(mag(right_reg));
                mul_b = MUL_W'(gain_reg);
            end
            ST_ENV_A: begin
                mul_a = MUL_W'(env_coef);
                mul_b = env_reg;
            end
            ST_ENV_B: begin
                mul_a = MUL_W'(ONE_Q24 - {1'b0, coef_reg});
                mul_b = peak_reg;
            end
            ST_FINAL_A: begin
                mul_a = MUL_W'(gain_reg);
                mul_b = MUL_W'(quot_reg);
            end
            ST_OUT_L: begin
                mul_a = MUL_W'(mag(left_reg));
                mul_b = MUL_W'(fgain_reg);
            end
            ST_OUT_R: begin
                mul_a = MUL_W'(mag(right_reg));
                mul_b = MUL_W'(fgain_reg);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Sequencer: next state and datapath updates.
    always_comb begin
        state_next  = state_reg;
        gain_next   = gain_reg;
        env_next    = env_reg;
        peak_next   = peak_reg;
        coef_next   = coef_reg;
        fgain_next  = fgain_reg;
        rem_next    = rem_reg;
        quot_next   = quot_reg;
        cnt_next    = cnt_reg;
        left_next   = left_reg;
        right_next  = right_reg;
        stereo_next = stereo_reg;
        out_l_next  = out_l_reg;
        out_r_next  = out_r_reg;
        acc_next    = acc_reg;
        case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    left_next   = sample_left;
                    right_next  = sample_right;
                    stereo_next = stereo_in;
                    if (cfg.enable) begin
                        state_next = ST_SMOOTH_A;
                    end else begin
                        out_l_next = sample_left;
                        out_r_next = stereo_in ? sample_right : '0;
                        state_next = ST_DONE;
                    end
                end
            end
            ST_SMOOTH_A: state_next = ST_SMOOTH_B;
            ST_SMOOTH_B: begin
                acc_next   = prod_reg;
                state_next = ST_SMOOTH_C;
            end
            ST_SMOOTH_C: begin
                gain_next  = sum_pole[24 +: GAIN_W];
                state_next = ST_PEAK_L;
            end
            ST_PEAK_L: state_next = ST_PEAK_R;
            ST_PEAK_R: begin
                peak_next  = prod_q20;
                state_next = ST_PEAK_C;
            end
            ST_PEAK_C: begin
                if (stereo_reg && (prod_q20 > peak_reg)) begin
                    peak_next = prod_q20;
                end
                state_next = ST_ENV_A;
            end
            ST_ENV_A: begin
                coef_next  = env_coef;
                state_next = ST_ENV_B;
            end
            ST_ENV_B: begin
                acc_next   = prod_reg;
                state_next = ST_ENV_C;
            end
            ST_ENV_C: begin
                env_next = env_new;
                // Above the threshold the reduction needs a division.
                if (env_new > ENV_W'(cfg.limit_threshold)) begin
                    rem_next   = ENV_W'(cfg.limit_threshold);
                    quot_next  = '0;
                    cnt_next   = 5'(GAIN_W - 1);
                    state_next = ST_DIV;
                end else begin
                    fgain_next = gain_reg;
                    state_next = ST_OUT_L;
                end
            end
            ST_DIV: begin
                // One restoring step per cycle; the remainder stays below the envelope.
                if (trial >= {1'b0, env_reg}) begin
                    rem_next  = ENV_W'(trial - {1'b0, env_reg});
                    quot_next = {quot_reg[GAIN_W-2:0], 1'b1};
                end else begin
                    rem_next  = trial[ENV_W-1:0];
                    quot_next = {quot_reg[GAIN_W-2:0], 1'b0};
                end
                if (cnt_reg == 5'd0) begin
                    state_next = ST_FINAL_A;
                end else begin
                    cnt_next = cnt_reg - 5'd1;
                end
            end
            ST_FINAL_A: state_next = ST_FINAL_C;
            ST_FINAL_C: begin
                fgain_next = sum_rnd24[24 +: GAIN_W];
                state_next = ST_OUT_L;
            end
            ST_OUT_L: state_next = ST_OUT_R;
            ST_OUT_R: begin
                out_l_next = sat(left_reg[SAMPLE_W-1], prod_q20);
                state_next = ST_OUT_C;
            end
            ST_OUT_C: begin
                out_r_next = stereo_reg ? sat(right_reg[SAMPLE_W-1], prod_q20) : '0;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Control state and the limiter state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            gain_reg  <= RST_SMOOTHED_GAIN;
            env_reg   <= RST_PEAK_ENVELOPE;
        end else begin
            state_reg <= state_next;
            gain_reg  <= gain_next;
            env_reg   <= env_next;
        end
    end

    // Working registers and the registered multiplier product.
    always_ff @(posedge aclk) begin
        peak_reg   <= peak_next;
        coef_reg   <= coef_next;
        fgain_reg  <= fgain_next;
        rem_reg    <= rem_next;
        quot_reg   <= quot_next;
        cnt_reg    <= cnt_next;
        left_reg   <= left_next;
        right_reg  <= right_next;
        stereo_reg <= stereo_next;
        out_l_reg  <= out_l_next;
        out_r_reg  <= out_r_next;
        acc_reg    <= acc_next;
        prod_reg   <= mul_a * mul_b;
    end

    assign idle      = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_DONE);
    assign res_left  = out_l_reg;
    assign res_right = out_r_reg;

endmodule

// ===== rtl/smoothed_gain_peak_limiter.sv =====
// ----------------------------------------------------------------------------
// Smoothed gain peak limiter
// Per-frame gain smoothing, peak envelope following and limiting for mono or
// stereo 24-bit audio, with a plain configuration write port.
// ----------------------------------------------------------------------------
// One frame is processed at a time by a sequencer that drives a single shared
// 28 by 28 bit registered multiplier. A frame is taken only after the previous
// result has left the core. While the envelope is above the threshold, a frame
// also goes through the 24-step restoring divider that forms threshold over
// envelope, and through the gain product after it. A disabled frame skips the
// processing. Results wait in an output register, so the next frame can be
// accepted while a result is still waiting to be taken.
module smoothed_gain_peak_limiter (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic signed [sgpl_pkg::SAMPLE_W-1:0]   s_sample_left,
    input  logic signed [sgpl_pkg::SAMPLE_W-1:0]   s_sample_right,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic signed [sgpl_pkg::SAMPLE_W-1:0]   m_out_left,
    output logic signed [sgpl_pkg::SAMPLE_W-1:0]   m_out_right,
    input  logic                                   cfg_wr_en,
    input  logic        [sgpl_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic        [sgpl_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import sgpl_pkg::*;

    cfg_t                 cfg_reg;
    logic                 core_idle;
    logic                 core_valid;
    logic                 core_ready;
    logic [SAMPLE_W-1:0]  core_left;
    logic [SAMPLE_W-1:0]  core_right;
    logic                 m_valid_reg;
    logic [SAMPLE_W-1:0]  m_left_reg;
    logic [SAMPLE_W-1:0]  m_right_reg;

    // Configuration register file.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.enable          <= RST_ENABLE;
            cfg_reg.channel_count   <= RST_CHANNEL_COUNT;
            cfg_reg.target_gain     <= RST_TARGET_GAIN;
            cfg_reg.limit_threshold <= RST_LIMIT_THRESHOLD;
            cfg_reg.attack_coeff    <= RST_ATTACK_COEFF;
            cfg_reg.release_coeff   <= RST_RELEASE_COEFF;
            cfg_reg.smooth_coeff    <= RST_SMOOTH_COEFF;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_ENABLE:          cfg_reg.enable          <= cfg_wdata[0];
                CFG_CHANNEL_COUNT:   cfg_reg.channel_count   <= cfg_wdata[1:0];
                CFG_TARGET_GAIN:     cfg_reg.target_gain     <= cfg_wdata[GAIN_W-1:0];
                CFG_LIMIT_THRESHOLD: cfg_reg.limit_threshold <= cfg_wdata[GAIN_W-1:0];
                CFG_ATTACK_COEFF:    cfg_reg.attack_coeff    <= cfg_wdata[COEFF_W-1:0];
                CFG_RELEASE_COEFF:   cfg_reg.release_coeff   <= cfg_wdata[COEFF_W-1:0];
                CFG_SMOOTH_COEFF:    cfg_reg.smooth_coeff    <= cfg_wdata[COEFF_W-1:0];
                default: ;
            endcase
        end
    end

    // Processing core.
    sgpl_core u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg_reg),
        .start        (s_valid && core_idle),
        .sample_left  (s_sample_left),
        .sample_right (s_sample_right),
        .idle         (core_idle),
        .res_valid    (core_valid),
        .res_ready    (core_ready),
        .res_left     (core_left),
        .res_right    (core_right)
    );

    // Output register: takes a result whenever it is empty or being emptied.
    assign core_ready = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (core_valid && core_ready) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (core_valid && core_ready) begin
            m_left_reg  <= core_left;
            m_right_reg <= core_right;
        end
    end

    assign s_ready     = core_idle;
    assign m_valid     = m_valid_reg;
    assign m_out_left  = m_left_reg;
    assign m_out_right = m_right_reg;

endmodule

// ===== rtl/sgpl_checker.sv =====
// ----------------------------------------------------------------------------
// Smoothed gain peak limiter checker
// Port-level assertions on the request and result channels, bound to the
// top level.
// ----------------------------------------------------------------------------
module sgpl_checker (
    input logic                                   aclk,
    input logic                                   aresetn,
    input logic                                   s_valid,
    input logic                                   s_ready,
    input logic signed [sgpl_pkg::SAMPLE_W-1:0]   s_sample_left,
    input logic signed [sgpl_pkg::SAMPLE_W-1:0]   s_sample_right,
    input logic                                   m_valid,
    input logic                                   m_ready,
    input logic signed [sgpl_pkg::SAMPLE_W-1:0]   m_out_left,
    input logic signed [sgpl_pkg::SAMPLE_W-1:0]   m_out_right
);

    // A waiting request keeps its valid and its payload.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_sample_left) && $stable(s_sample_right))
        else $error("waiting request changed or was withdrawn");

    // A stalled result keeps its valid and its payload.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_left) && $stable(m_out_right))
        else $error("stalled result changed or was dropped");

    // Reset leaves no result pending.
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid straight after reset");

    // An accepted request keeps the block busy in the following cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request taken while previous one still in flight");

    // A request taken while no result is pending never makes a result valid immediately.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && !m_valid |=> !m_valid)
        else $error("result appeared without processing time");

endmodule

bind smoothed_gain_peak_limiter sgpl_checker u_sgpl_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .s_sample_left  (s_sample_left),
    .s_sample_right (s_sample_right),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_out_left     (m_out_left),
    .m_out_right    (m_out_right)
);
